// ===== rtl/casna_pkg.sv =====
package casna_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int BOUND_W    = ANGLE_BITS + 1;
  localparam int REG_ARCS   = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  localparam logic [BOUND_W-1:0] TURN = BOUND_W'(1) << ANGLE_BITS;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_ARC_COUNT = 3'd0;
  localparam reg_idx_t REG_LOW_A     = 3'd1;
  localparam reg_idx_t REG_HIGH_A    = 3'd2;
  localparam reg_idx_t REG_LOW_B     = 3'd3;
  localparam reg_idx_t REG_HIGH_B    = 3'd4;
  localparam reg_idx_t REG_LOW_C     = 3'd5;
  localparam reg_idx_t REG_HIGH_C    = 3'd6;

  typedef struct packed {
    logic                  v;
    logic [BOUND_W-1:0]    cd;
    logic [ANGLE_BITS-1:0] e;
  } cand_t;

  function automatic logic [BOUND_W-1:0] sat_bound(input logic [BOUND_W-1:0] b);
    sat_bound = (b > TURN) ? TURN : b;
  endfunction

  // lexicographic min on (distance, endpoint); invalid candidates lose
  function automatic cand_t cand_min(input cand_t a, input cand_t b);
    cand_t r;
    if (!a.v) begin
      r = b;
    end else if (!b.v) begin
      r = a;
    end else if ((b.cd < a.cd) || ((b.cd == a.cd) && (b.e < a.e))) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

// ===== rtl/circular_arc_set_nearest_angle_core.sv =====
// Channel   Handshake               Payload
// request   start, busy (always 0)  in_query_angle
// result    out_valid strobe        out_found, out_inside_res, out_nearest
// config    APB write/read          cfg_paddr, cfg_pwdata, cfg_prdata
//
// One request per cycle, each answered by an out_valid strobe.
// Each request passes four register stages: endpoint distance, circular
// distance, per-arc minimum, final minimum into the output registers.
// Synchronous active-low reset clears valids and config, HIGH_A to TURN.
// The receiver cannot stall, so busy stays low and nothing is held back.
module circular_arc_set_nearest_angle_core #(
  parameter int MAX_ARCS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [casna_pkg::ANGLE_BITS-1:0]    in_query_angle,
  output logic                                out_valid,
  output logic                                out_found,
  output logic                                out_inside_res,
  output logic [casna_pkg::ANGLE_BITS-1:0]    out_nearest,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [casna_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [casna_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [casna_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import casna_pkg::*;

  localparam int NEP = 2 * MAX_ARCS;

  // config registers
  logic [1:0]         arc_count_r;
  logic [BOUND_W-1:0] bnd_r [2*REG_ARCS];
  reg_idx_t           cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign busy       = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arc_count_r <= '0;
      for (int i = 0; i < 2*REG_ARCS; i++) begin
        bnd_r[i] <= '0;
      end
      bnd_r[1] <= TURN;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ARC_COUNT: arc_count_r <= cfg_pwdata[1:0];
        REG_LOW_A:     bnd_r[0] <= cfg_pwdata[BOUND_W-1:0];
        REG_HIGH_A:    bnd_r[1] <= cfg_pwdata[BOUND_W-1:0];
        REG_LOW_B:     bnd_r[2] <= cfg_pwdata[BOUND_W-1:0];
        REG_HIGH_B:    bnd_r[3] <= cfg_pwdata[BOUND_W-1:0];
        REG_LOW_C:     bnd_r[4] <= cfg_pwdata[BOUND_W-1:0];
        REG_HIGH_C:    bnd_r[5] <= cfg_pwdata[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ARC_COUNT: cfg_prdata = CFG_DATA_W'(arc_count_r);
      REG_LOW_A:     cfg_prdata = CFG_DATA_W'(bnd_r[0]);
      REG_HIGH_A:    cfg_prdata = CFG_DATA_W'(bnd_r[1]);
      REG_LOW_B:     cfg_prdata = CFG_DATA_W'(bnd_r[2]);
      REG_HIGH_B:    cfg_prdata = CFG_DATA_W'(bnd_r[3]);
      REG_LOW_C:     cfg_prdata = CFG_DATA_W'(bnd_r[4]);
      REG_HIGH_C:    cfg_prdata = CFG_DATA_W'(bnd_r[5]);
      default:       cfg_prdata = '0;
    endcase
  end

  // stage 1: containment and linear endpoint distance
  logic                  v1_r, f1_r;
  logic [ANGLE_BITS-1:0] ang1_r;
  logic [MAX_ARCS-1:0]   ins1_r, ins1_nxt;
  logic [NEP-1:0]        cv1_r, cv1_nxt;
  logic [ANGLE_BITS-1:0] e1_r [NEP];
  logic [ANGLE_BITS-1:0] e1_nxt [NEP];
  logic [ANGLE_BITS-1:0] d1_r [NEP];
  logic [ANGLE_BITS-1:0] d1_nxt [NEP];

  always_comb begin
    logic [BOUND_W-1:0] lo, hi, sb;
    logic [BOUND_W-1:0] ang_x;
    ang_x = BOUND_W'(in_query_angle);
    for (int i = 0; i < MAX_ARCS; i++) begin
      lo = sat_bound(bnd_r[2*i]);
      hi = sat_bound(bnd_r[2*i+1]);
      ins1_nxt[i] = (arc_count_r > 2'(i)) && (ang_x >= lo) && (ang_x <= hi);
    end
    for (int k = 0; k < NEP; k++) begin
      sb = sat_bound(bnd_r[k]);
      e1_nxt[k]  = (sb == TURN) ? '0 : sb[ANGLE_BITS-1:0];
      d1_nxt[k]  = (e1_nxt[k] > in_query_angle) ? (e1_nxt[k] - in_query_angle)
                                                : (in_query_angle - e1_nxt[k]);
      cv1_nxt[k] = arc_count_r > 2'(k / 2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    f1_r   <= arc_count_r != 2'd0;
    ang1_r <= in_query_angle;
    ins1_r <= ins1_nxt;
    cv1_r  <= cv1_nxt;
    for (int k = 0; k < NEP; k++) begin
      e1_r[k] <= e1_nxt[k];
      d1_r[k] <= d1_nxt[k];
    end
  end

  // stage 2: circular distance
  logic                  v2_r, f2_r, ins2_r;
  logic [ANGLE_BITS-1:0] ang2_r;
  cand_t                 c2_r [NEP];
  cand_t                 c2_nxt [NEP];

  always_comb begin
    logic [BOUND_W-1:0] dx, rd;
    for (int k = 0; k < NEP; k++) begin
      dx = BOUND_W'(d1_r[k]);
      rd = TURN - dx;
      c2_nxt[k].v  = cv1_r[k];
      c2_nxt[k].cd = (rd < dx) ? rd : dx;
      c2_nxt[k].e  = e1_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    f2_r   <= f1_r;
    ins2_r <= |ins1_r;
    ang2_r <= ang1_r;
    for (int k = 0; k < NEP; k++) begin
      c2_r[k] <= c2_nxt[k];
    end
  end

  // stage 3: best endpoint of each arc
  logic                  v3_r, f3_r, ins3_r;
  logic [ANGLE_BITS-1:0] ang3_r;
  cand_t                 c3_r [MAX_ARCS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    f3_r   <= f2_r;
    ins3_r <= ins2_r;
    ang3_r <= ang2_r;
    for (int i = 0; i < MAX_ARCS; i++) begin
      c3_r[i] <= cand_min(c2_r[2*i], c2_r[2*i+1]);
    end
  end

  // stage 4: best over arcs, output registers
  logic                  out_valid_r, out_found_r, out_inside_r;
  logic [ANGLE_BITS-1:0] out_nearest_r, nearest_nxt;

  always_comb begin
    cand_t best;
    best = c3_r[0];
    for (int i = 1; i < MAX_ARCS; i++) begin
      best = cand_min(best, c3_r[i]);
    end
    if (!f3_r) begin
      nearest_nxt = '0;
    end else if (ins3_r) begin
      nearest_nxt = ang3_r;
    end else begin
      nearest_nxt = best.e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v3_r;
    end
    out_found_r   <= f3_r;
    out_inside_r  <= ins3_r;
    out_nearest_r <= nearest_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_inside_res = out_inside_r;
  assign out_nearest    = out_nearest_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4))
    else $error("result without matching request");
  a_inside_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_res) |-> out_found)
    else $error("inside reported on empty set");
  a_inside_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_res) |-> (out_nearest == $past(in_query_angle, 4)))
    else $error("inside result does not return query angle");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_nearest == '0 && !out_inside_res))
    else $error("empty set result not zero");
`endif

endmodule

// ===== tb/sv/circular_arc_set_nearest_angle_core_tb.sv =====
module circular_arc_set_nearest_angle_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import casna_pkg::*;

  localparam int unsigned TURN_U     = 1 << ANGLE_BITS;
  localparam int          PIPE_SLACK = 8;
  localparam int          PHASES     = 8;
  localparam int          PHASE_LEN  = 60;
  localparam reg_idx_t    REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                  found;
    logic                  ins_res;
    logic [ANGLE_BITS-1:0] nearest;
  } arc_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [ANGLE_BITS-1:0] in_query_angle;
  logic                  out_valid;
  logic                  out_found;
  logic                  out_inside_res;
  logic [ANGLE_BITS-1:0] out_nearest;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // shadow copy of the arc registers
  logic [1:0]            arc_cnt;
  logic [BOUND_W-1:0]    arc_bound [6];

  arc_result_t           pending_results [$];
  int                    n_errors;
  int                    n_requests;
  int                    n_results;
  int                    n_configs;

  circular_arc_set_nearest_angle_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_query_angle(in_query_angle),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_inside_res(out_inside_res),
    .out_nearest   (out_nearest),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned clamp_bound(input logic [BOUND_W-1:0] b);
    return (int'(b) > TURN_U) ? TURN_U : int'(b);
  endfunction

  function automatic arc_result_t nearest_allowed(input logic [ANGLE_BITS-1:0] angle);
    arc_result_t r;
    int unsigned a, lo, hi, e, d, cd, best, best_d, n;
    bit have, ins;
    r = '0;
    a = angle;
    n = arc_cnt;
    have = 0;
    ins = 0;
    best = 0;
    best_d = 0;
    if (n > REG_ARCS) n = REG_ARCS;
    if (n == 0) return r;
    for (int i = 0; i < n; i++) begin
      lo = clamp_bound(arc_bound[2*i]);
      hi = clamp_bound(arc_bound[2*i+1]);
      if (a >= lo && a <= hi) ins = 1;
    end
    if (ins) begin
      best = a;
    end else begin
      for (int i = 0; i < 2*n; i++) begin
        e = clamp_bound(arc_bound[i]);
        if (e >= TURN_U) e = 0;
        d = (e > a) ? e - a : a - e;
        cd = ((TURN_U - d) < d) ? TURN_U - d : d;
        if (!have || cd < best_d || (cd == best_d && e < best)) begin
          best = e;
          best_d = cd;
          have = 1;
        end
      end
    end
    r.found = 1'b1;
    r.ins_res = ins;
    r.nearest = best[ANGLE_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    arc_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual %0d/%0d/%0d",
                   $time, out_found, out_inside_res, out_nearest);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, want.found, out_found);
            n_errors++;
          end
          if (out_inside_res !== want.ins_res) begin
            $display("%0t: inside_res mismatch, expected %0d, actual %0d",
                     $time, want.ins_res, out_inside_res);
            n_errors++;
          end
          if (out_nearest !== want.nearest) begin
            $display("%0t: nearest mismatch, expected %0d, actual %0d",
                     $time, want.nearest, out_nearest);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        pending_results.insert(pending_results.size(), nearest_allowed(in_query_angle));
        n_requests++;
      end
    end
  end

  function automatic int pick_gap(input bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_query(input logic [ANGLE_BITS-1:0] angle, input int gap);
    start <= 1'b1;
    in_query_angle <= angle;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_ARC_COUNT: arc_cnt = val[1:0];
      REG_LOW_A, REG_HIGH_A, REG_LOW_B, REG_HIGH_B, REG_LOW_C, REG_HIGH_C:
        arc_bound[int'(idx) - 1] = val[BOUND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_arcs(input logic [31:0] cnt, la, ha, lb, hb, lc, hc);
    drain_results();
    write_reg(REG_ARC_COUNT, cnt);
    write_reg(REG_LOW_A, la);
    write_reg(REG_HIGH_A, ha);
    write_reg(REG_LOW_B, lb);
    write_reg(REG_HIGH_B, hb);
    write_reg(REG_LOW_C, lc);
    write_reg(REG_HIGH_C, hc);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    n_configs++;
  endtask

  task automatic test_empty_set();
    send_query(16'd0, pick_gap(1));
    send_query(16'hffff, pick_gap(1));
    send_query(16'h8000, pick_gap(1));
    send_query(16'd1, pick_gap(1));
  endtask

  task automatic test_full_circle();
    program_arcs(1, 0, TURN_U, 0, 0, 0, 0);
    send_query(16'd0, pick_gap(1));
    send_query(16'hffff, pick_gap(1));
  endtask

  task automatic test_wrap_and_ties();
    program_arcs(2, 100, 200, 300, 400, 0, 0);
    send_query(16'd250, 0);
    send_query(16'd50, 0);
    send_query(16'd401, 0);
    send_query(16'd65500, 0);
    // endpoint at a full turn folds to zero
    program_arcs(1, TURN_U, TURN_U, 0, 0, 0, 0);
    send_query(16'd0, 0);
    send_query(16'd40000, 0);
    // equidistant across the wrap
    program_arcs(2, 16384, 16384, 49152, 49152, 0, 0);
    send_query(16'd0, 0);
    send_query(16'h8000, 0);
  endtask

  task automatic test_reversed_and_saturated();
    program_arcs(32'hffff_fffe, 40000, 30000, 32'h1ffff, 32'hffff_ffff, 1000, 2000);
    send_query(16'd35000, pick_gap(1));
    send_query(16'hffff, pick_gap(1));
    send_query(16'd0, pick_gap(1));
    send_query(16'd1500, pick_gap(1));
  endtask

  task automatic test_unused_register();
    drain_results();
    write_reg(REG_UNUSED, 32'h0000_1234);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    send_query(16'd1500, pick_gap(1));
    send_query(16'd20000, pick_gap(1));
  endtask

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return TURN_U;
      2: return TURN_U - 1;
      3: return $urandom_range(TURN_U + 1, 32'h1ffff);
      4: return $urandom;
      default: return $urandom_range(0, TURN_U - 1);
    endcase
  endfunction

  function automatic logic [ANGLE_BITS-1:0] pick_query();
    int unsigned p, q;
    case ($urandom_range(0, 9))
      5, 6: begin
        p = arc_bound[$urandom_range(0, 5)];
        return ANGLE_BITS'(p + $urandom_range(0, 4) - 2);
      end
      7: begin
        p = clamp_bound(arc_bound[$urandom_range(0, 5)]);
        q = clamp_bound(arc_bound[$urandom_range(0, 5)]);
        return ANGLE_BITS'((p + q) / 2 + ($urandom_range(0, 1) ? TURN_U / 2 : 0));
      end
      8: return $urandom_range(0, 1) ? '1 : '0;
      default: return ANGLE_BITS'($urandom);
    endcase
  endfunction

  task automatic test_random_arcs();
    logic [31:0] pts [6];
    logic [31:0] tmp, cnt;
    bit idle_on;
    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < 6; i++)
        pts[i] = (p % 2 == 0) ? $urandom_range(0, TURN_U) : pick_bound();
      if (p % 2 == 0) begin
        for (int i = 1; i < 6; i++)
          for (int j = i; j > 0 && pts[j-1] > pts[j]; j--) begin
            tmp = pts[j];
            pts[j] = pts[j-1];
            pts[j-1] = tmp;
          end
      end
      if (p == 0) cnt = 3;
      else if ($urandom_range(0, 5) == 0) cnt = 0;
      else cnt = $urandom_range(1, 3);
      if (p == 5) cnt = cnt | ($urandom & 32'hffff_fffc);
      program_arcs(cnt, pts[0], pts[1], pts[2], pts[3], pts[4], pts[5]);
      idle_on = (p % 3 != 1);
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (p == 2 && k == PHASE_LEN / 2) drain_results();
        send_query(pick_query(), pick_gap(idle_on));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_query_angle <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    arc_cnt = '0;
    for (int i = 0; i < 6; i++) arc_bound[i] = '0;
    arc_bound[1] = TURN;
    n_errors = 0;
    n_requests = 0;
    n_results = 0;
    n_configs = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_set();
    test_full_circle();
    test_wrap_and_ties();
    test_reversed_and_saturated();
    test_unused_register();
    test_random_arcs();
    drain_results();

    $display("Sent %0d angle queries over %0d arc settings, checked %0d results.",
             n_requests, n_configs, n_results);
    $display("Covered empty, wrapped, reversed and saturated arcs, ties and idle gaps.");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/casna_pkg.sv
rtl/circular_arc_set_nearest_angle_core.sv
tb/sv/circular_arc_set_nearest_angle_core_tb.sv
